// ===== hdl/xcr_pkg.sv =====
`default_nettype none
package xcr_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int BUF_BYTES   = 65536;

  localparam int IDX_W  = $clog2(BLOCK_BYTES);
  localparam int OFF_W  = 17;
  localparam int ADDR_W = 16;
  localparam int CNT_W  = 24;
  localparam int STAT_W = 3;

  localparam logic [CNT_W-1:0] NAK_INTERVAL_RESET = 24'd2000000;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] HDR_CHECK = 8'hff;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_IDLE = 1'b1;

  localparam logic [STAT_W-1:0] ST_RUNNING  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DONE     = 3'd1;
  localparam logic [STAT_W-1:0] ST_CANCEL   = 3'd2;
  localparam logic [STAT_W-1:0] ST_PROTO    = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd4;

  typedef enum logic [2:0] {
    PH_CMD,
    PH_NUM,
    PH_INV,
    PH_DATA,
    PH_SUM,
    PH_FINISHED
  } phase_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        rx_byte;
  } item_t;

  typedef struct packed {
    logic              send_valid;
    logic [7:0]        send_byte;
    logic              write_valid;
    logic [ADDR_W-1:0] write_addr;
    logic [7:0]        write_data;
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  size;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/xcr_in_stage.sv =====
`default_nettype none
module xcr_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic           in_kind,
  input  wire logic [7:0]     in_rx_byte,
  input  wire logic           adv,
  output logic                step_en,
  output xcr_pkg::item_t      item
);
  import xcr_pkg::*;

  logic  vld_r;
  item_t item_r;

  assign in_stall = vld_r && !adv;
  assign step_en  = vld_r && adv;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.kind    <= in_kind;
      item_r.rx_byte <= in_rx_byte;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/xcr_engine.sv =====
`default_nettype none
module xcr_engine (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step_en,
  input  wire xcr_pkg::item_t             item,
  input  wire logic [xcr_pkg::CNT_W-1:0]  nak_interval,
  output xcr_pkg::result_t                res
);
  import xcr_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [7:0]        exp_blk_r, exp_blk_nxt;
  logic [7:0]        hdr_num_r, hdr_num_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic              started_r, started_nxt;
  logic [CNT_W-1:0]  idle_r, idle_nxt;
  logic [STAT_W-1:0] final_r, final_nxt;

  logic              is_byte;
  logic [7:0]        c;
  logic              overflow;
  logic              last_idx;
  logic [CNT_W-1:0]  idle_inc;
  logic [7:0]        sum_add;

  assign is_byte  = (item.kind == KIND_BYTE);
  assign c        = item.rx_byte;
  assign overflow = ({1'b0, off_r} + (OFF_W+1)'(BLOCK_BYTES)) > (OFF_W+1)'(BUF_BYTES);
  assign last_idx = (idx_r == IDX_W'(BLOCK_BYTES - 1));
  assign idle_inc = idle_r + CNT_W'(1);
  assign sum_add  = sum_r + c;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (is_byte) begin
      case (phase_r)
        PH_CMD: begin
          if (c == CH_EOT || c == CH_CAN) begin
            phase_nxt = PH_FINISHED;
          end else if (c == CH_SOH) begin
            phase_nxt = overflow ? PH_FINISHED : PH_NUM;
          end else if (started_r) begin
            phase_nxt = PH_FINISHED;
          end
        end
        PH_NUM:  phase_nxt = (c == exp_blk_r) ? PH_INV : PH_CMD;
        PH_INV:  phase_nxt = ((hdr_num_r ^ c) == HDR_CHECK) ? PH_DATA : PH_CMD;
        PH_DATA: phase_nxt = last_idx ? PH_SUM : PH_DATA;
        PH_SUM:  phase_nxt = PH_CMD;
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    exp_blk_nxt = exp_blk_r;
    hdr_num_nxt = hdr_num_r;
    idx_nxt     = idx_r;
    sum_nxt     = sum_r;
    off_nxt     = off_r;
    started_nxt = started_r;
    idle_nxt    = idle_r;
    final_nxt   = final_r;
    res         = '0;
    if (!is_byte) begin
      if (phase_r == PH_CMD && !started_r) begin
        if (idle_inc >= nak_interval) begin
          idle_nxt       = '0;
          res.send_valid = 1'b1;
          res.send_byte  = CH_NAK;
        end else begin
          idle_nxt = idle_inc;
        end
      end
    end else begin
      case (phase_r)
        PH_CMD: begin
          idle_nxt = '0;
          if (c == CH_EOT) begin
            res.send_valid = 1'b1;
            res.send_byte  = CH_ACK;
            final_nxt      = ST_DONE;
          end else if (c == CH_CAN) begin
            final_nxt = ST_CANCEL;
          end else if (c == CH_SOH) begin
            started_nxt = 1'b1;
            if (overflow) begin
              final_nxt = ST_OVERFLOW;
            end
          end else if (started_r) begin
            final_nxt = ST_PROTO;
          end
        end
        PH_NUM: begin
          if (c != exp_blk_r) begin
            res.send_valid = 1'b1;
            res.send_byte  = CH_NAK;
          end else begin
            hdr_num_nxt = c;
          end
        end
        PH_INV: begin
          if ((hdr_num_r ^ c) != HDR_CHECK) begin
            res.send_valid = 1'b1;
            res.send_byte  = CH_NAK;
          end else begin
            idx_nxt = '0;
            sum_nxt = '0;
          end
        end
        PH_DATA: begin
          res.write_valid = 1'b1;
          res.write_addr  = ADDR_W'(off_r + OFF_W'(idx_r));
          res.write_data  = c;
          sum_nxt         = sum_add;
          idx_nxt         = last_idx ? '0 : idx_r + IDX_W'(1);
        end
        PH_SUM: begin
          res.send_valid = 1'b1;
          if ((sum_r ^ c) != 8'h00) begin
            res.send_byte = CH_NAK;
          end else begin
            res.send_byte = CH_ACK;
            exp_blk_nxt   = exp_blk_r + 8'd1;
            off_nxt       = off_r + OFF_W'(BLOCK_BYTES);
          end
        end
        default: ;
      endcase
    end
    res.status = final_nxt;
    res.size   = off_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_CMD;
      exp_blk_r <= 8'd1;
      hdr_num_r <= '0;
      idx_r     <= '0;
      sum_r     <= '0;
      off_r     <= '0;
      started_r <= 1'b0;
      idle_r    <= '0;
      final_r   <= ST_RUNNING;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      exp_blk_r <= exp_blk_nxt;
      hdr_num_r <= hdr_num_nxt;
      idx_r     <= idx_nxt;
      sum_r     <= sum_nxt;
      off_r     <= off_nxt;
      started_r <= started_nxt;
      idle_r    <= idle_nxt;
      final_r   <= final_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/xcr_out_stage.sv =====
`default_nettype none
module xcr_out_stage (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step_en,
  input  wire xcr_pkg::result_t             res,
  output logic                              adv,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_send_valid,
  output logic [7:0]                        out_send_byte,
  output logic                              out_write_valid,
  output logic [xcr_pkg::ADDR_W-1:0]        out_write_addr,
  output logic [7:0]                        out_write_data,
  output logic [xcr_pkg::STAT_W-1:0]        out_status,
  output logic [xcr_pkg::OFF_W-1:0]         out_size
);
  import xcr_pkg::*;

  logic    vld_r;
  result_t res_r;

  assign adv       = !vld_r || !out_stall;
  assign out_valid = vld_r;

  assign out_send_valid  = res_r.send_valid;
  assign out_send_byte   = res_r.send_byte;
  assign out_write_valid = res_r.write_valid;
  assign out_write_addr  = res_r.write_addr;
  assign out_write_data  = res_r.write_data;
  assign out_status      = res_r.status;
  assign out_size        = res_r.size;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= step_en;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/xmodem_checksum_receiver.sv =====
// channel  ports                                   beat
// in       in_valid / in_stall                     kind, rx_byte (byte or idle tick)
// out      out_valid / out_stall                   reply, buffer write, status, size
// cfg      cfg_we / cfg_wdata                      nak_interval, no read-back
//
// one beat in per cycle while in_stall is low; each beat gives one result beat, passing
// through input register, one pass of protocol logic, result register
// rst_n is synchronous: phase to command wait, block number 1, nak_interval 2000000
// out_stall holds the result register and backs up into in_stall only when
// both registers are full
`default_nettype none
module xmodem_checksum_receiver (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [xcr_pkg::CNT_W-1:0]    cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_kind,
  input  wire logic [7:0]                   in_rx_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_send_valid,
  output logic [7:0]                        out_send_byte,
  output logic                              out_write_valid,
  output logic [xcr_pkg::ADDR_W-1:0]        out_write_addr,
  output logic [7:0]                        out_write_data,
  output logic [xcr_pkg::STAT_W-1:0]        out_status,
  output logic [xcr_pkg::OFF_W-1:0]         out_size
);
  import xcr_pkg::*;

  logic [CNT_W-1:0] nak_interval_r;
  logic             adv;
  logic             step_en;
  item_t            item;
  result_t          res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nak_interval_r <= NAK_INTERVAL_RESET;
    end else if (cfg_we) begin
      nak_interval_r <= cfg_wdata;
    end
  end

  xcr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_rx_byte (in_rx_byte),
    .adv        (adv),
    .step_en    (step_en),
    .item       (item)
  );

  xcr_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step_en),
    .item         (item),
    .nak_interval (nak_interval_r),
    .res          (res)
  );

  xcr_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (step_en),
    .res             (res),
    .adv             (adv),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_send_valid  (out_send_valid),
    .out_send_byte   (out_send_byte),
    .out_write_valid (out_write_valid),
    .out_write_addr  (out_write_addr),
    .out_write_data  (out_write_data),
    .out_status      (out_status),
    .out_size        (out_size)
  );

endmodule
`default_nettype wire
